@@ design/grid_bilinear_interpolator_defines.svh @@
// assertion macros for the grid bilinear interpolator
`ifndef GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GBI_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("grid interpolator check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GBI_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("grid interpolator check failed");

`endif

@@ design/gbi_pkg.sv @@
// shared types and constants of the grid bilinear interpolator
package gbi_pkg;

	// item kinds carried on the input tuser
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_X_ORIGIN    = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN    = 3'd1;
	localparam logic [2:0] REG_X_INV_WIDTH = 3'd2;
	localparam logic [2:0] REG_Y_INV_WIDTH = 3'd3;
	localparam logic [2:0] REG_X_POINTS    = 3'd4;
	localparam logic [2:0] REG_Y_POINTS    = 3'd5;

	// weight of 1.0 in 16 fraction bits
	localparam logic [16:0] WEIGHT_ONE = 17'h10000;

	// per-query control handed from the lookup stage to the blend pipe
	typedef struct packed {
		logic        valid;
		logic        oor;
		logic [15:0] dx;
		logic [15:0] dy;
		logic        x0p;
		logic        x1p;
		logic        y0p;
		logic        y1p;
	} gbi_ctl_t;

endpackage

@@ design/grid_bilinear_interpolator.sv @@
// top level of the grid bilinear interpolator
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: bins, sample, point; tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: interp_value; tuser: out_of_range
// cfg       in   cfg_we                         cfg_index, cfg_data
//
// one transaction per cycle in, one result per query out
// the rate is set by the nine-stage pipe with one shared enable; it moves whenever the
// output register is empty or being taken
// sample store is four parity banks, so the four corners come out in the same cycle
// write transactions update the store in stage 3 and leave no result
// reset clears valid bits and configuration; the sample store is not cleared
// a stall on m_axis freezes every stage, nothing lost or repeated
`include "grid_bilinear_interpolator_defines.svh"

module grid_bilinear_interpolator #(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// slave stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [111:0]  s_axis_tdata,  // x_bin, y_bin, sample_value, x_coord, y_coord, zero pad
	input  logic [0:0]    s_axis_tuser,  // mode
	// master stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,  // interp_value
	output logic [0:0]    m_axis_tuser,  // out_of_range
	// configuration
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int XW  = $clog2(MAX_X_POINTS);
	localparam int YW  = $clog2(MAX_Y_POINTS);
	localparam int XHW = (XW > 1) ? XW - 1 : 1;
	localparam int YHW = (YW > 1) ? YW - 1 : 1;
	localparam int AW  = XHW + YHW;

	// configuration registers
	logic signed [31:0] x_origin_q, y_origin_q;
	logic [31:0]        x_inv_width_q, y_inv_width_q;
	logic [6:0]         x_points_q, y_points_q;

	// pipeline control
	logic               en;
	logic               v_s1, v_s2, v_s3;
	logic               mode_s1, mode_s2, mode_s3;
	logic [5:0]         x_bin_s1, x_bin_s2, x_bin_s3;
	logic [5:0]         y_bin_s1, y_bin_s2, y_bin_s3;
	logic [31:0]        sample_s1, sample_s2, sample_s3;

	// axis mapping results at stage 3
	logic [XW-1:0]      x_last, x_idx0_s3, x_idx1_s3;
	logic [YW-1:0]      y_last, y_idx0_s3, y_idx1_s3;
	logic [15:0]        dx_s3, dy_s3;
	logic               x_oor_s3, y_oor_s3;

	// store access
	logic               wr_ok;
	logic [AW-1:0]      wr_addr;
	logic [3:0][31:0]   corner_s4;
	gbi_pkg::gbi_ctl_t  ctl_s4;

	logic               blend_valid;
	logic [31:0]        blend_value;
	logic               blend_oor;

	// configuration writes, only while idle: the user must keep to this, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q    <= '0;
			y_origin_q    <= '0;
			x_inv_width_q <= 32'h0001_0000;
			y_inv_width_q <= 32'h0001_0000;
			x_points_q    <= 7'd64;
			y_points_q    <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbi_pkg::REG_X_ORIGIN:    x_origin_q    <= cfg_data;
				gbi_pkg::REG_Y_ORIGIN:    y_origin_q    <= cfg_data;
				gbi_pkg::REG_X_INV_WIDTH: x_inv_width_q <= cfg_data;
				gbi_pkg::REG_Y_INV_WIDTH: y_inv_width_q <= cfg_data;
				gbi_pkg::REG_X_POINTS:    x_points_q    <= cfg_data[6:0];
				gbi_pkg::REG_Y_POINTS:    y_points_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// last usable grid index per axis, point count clamped to [2, max]
	always_comb begin
		priority if (x_points_q < 7'd2) begin
			x_last = XW'(1);
		end else if (32'(x_points_q) > 32'(MAX_X_POINTS)) begin
			x_last = XW'(MAX_X_POINTS - 1);
		end else begin
			x_last = XW'(x_points_q - 7'd1);
		end
		priority if (y_points_q < 7'd2) begin
			y_last = YW'(1);
		end else if (32'(y_points_q) > 32'(MAX_Y_POINTS)) begin
			y_last = YW'(MAX_Y_POINTS - 1);
		end else begin
			y_last = YW'(y_points_q - 7'd1);
		end
	end

	// whole pipe advances together; output register frees the input side
	assign en            = !blend_valid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// write fields ride along to the store stage
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= s_axis_tuser[0];
			x_bin_s1  <= s_axis_tdata[5:0];
			y_bin_s1  <= s_axis_tdata[11:6];
			sample_s1 <= s_axis_tdata[43:12];
			mode_s2   <= mode_s1;
			x_bin_s2  <= x_bin_s1;
			y_bin_s2  <= y_bin_s1;
			sample_s2 <= sample_s1;
			mode_s3   <= mode_s2;
			x_bin_s3  <= x_bin_s2;
			y_bin_s3  <= y_bin_s2;
			sample_s3 <= sample_s2;
		end
	end

	// subtract, multiply, range check: stages 1 to 3
	gbi_map_axis #(.IW(XW)) u_map_x (
		.clk    (clk),
		.en     (en),
		.coord  ($signed(s_axis_tdata[75:44])),
		.origin (x_origin_q),
		.inv    (x_inv_width_q),
		.last   (x_last),
		.idx0   (x_idx0_s3),
		.idx1   (x_idx1_s3),
		.weight (dx_s3),
		.oor    (x_oor_s3)
	);

	gbi_map_axis #(.IW(YW)) u_map_y (
		.clk    (clk),
		.en     (en),
		.coord  ($signed(s_axis_tdata[107:76])),
		.origin (y_origin_q),
		.inv    (y_inv_width_q),
		.last   (y_last),
		.idx0   (y_idx0_s3),
		.idx1   (y_idx1_s3),
		.weight (dy_s3),
		.oor    (y_oor_s3)
	);

	// writes beyond the store are dropped
	assign wr_ok = en && v_s3 && (mode_s3 == gbi_pkg::MODE_WRITE) &&
		(32'(x_bin_s3) < 32'(MAX_X_POINTS)) && (32'(y_bin_s3) < 32'(MAX_Y_POINTS));
	assign wr_addr = {XHW'(x_bin_s3 >> 1), YHW'(y_bin_s3 >> 1)};

	// bank {x parity, y parity}; neighbouring indices always land in different banks
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BX = 1'(b / 2);
		localparam logic BY = 1'(b % 2);

		logic [XW-1:0] rd_x;
		logic [YW-1:0] rd_y;

		assign rd_x = (x_idx0_s3[0] == BX) ? x_idx0_s3 : x_idx1_s3;
		assign rd_y = (y_idx0_s3[0] == BY) ? y_idx0_s3 : y_idx1_s3;

		gbi_sample_bank #(.AW(AW)) u_bank (
			.clk     (clk),
			.rd_en   (en),
			.rd_addr ({XHW'(rd_x >> 1), YHW'(rd_y >> 1)}),
			.wr_en   (wr_ok && (x_bin_s3[0] == BX) && (y_bin_s3[0] == BY)),
			.wr_addr (wr_addr),
			.wr_data (sample_s3),
			.rd_data (corner_s4[b])
		);
	end

	// query control aligned with the registered bank outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4.valid <= v_s3 && (mode_s3 == gbi_pkg::MODE_QUERY);
			ctl_s4.oor   <= x_oor_s3 || y_oor_s3;
			ctl_s4.dx    <= dx_s3;
			ctl_s4.dy    <= dy_s3;
			ctl_s4.x0p   <= x_idx0_s3[0];
			ctl_s4.x1p   <= x_idx1_s3[0];
			ctl_s4.y0p   <= y_idx0_s3[0];
			ctl_s4.y1p   <= y_idx1_s3[0];
		end
	end

	// stages 5 to 9
	gbi_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctl          (ctl_s4),
		.corner       (corner_s4),
		.valid        (blend_valid),
		.interp_value (blend_value),
		.out_of_range (blend_oor)
	);

	assign m_axis_tvalid   = blend_valid;
	assign m_axis_tdata    = blend_value;
	assign m_axis_tuser[0] = blend_oor;

	// checks
	`GBI_ASSERT_IMPL(a_oor_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)
	`GBI_ASSERT_IMPL(a_x_neighbour, v_s3 && (mode_s3 == gbi_pkg::MODE_QUERY) && !x_oor_s3, (x_idx1_s3 == x_idx0_s3) || (x_idx1_s3 == x_idx0_s3 + XW'(1)))
	`GBI_ASSERT_NEXT(a_query_reaches_blend, en && v_s3 && (mode_s3 == gbi_pkg::MODE_QUERY), ctl_s4.valid)
	`GBI_ASSERT_NEXT(a_write_no_result, en && v_s3 && (mode_s3 == gbi_pkg::MODE_WRITE), !ctl_s4.valid)

endmodule

@@ design/gbi_map_axis.sv @@
// maps one coordinate into grid units: lower index, upper index, weight, range flag
module gbi_map_axis #(
	parameter int IW = 6
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [31:0]   coord,
	input  logic signed [31:0]   origin,
	input  logic        [31:0]   inv,
	input  logic        [IW-1:0] last,
	output logic        [IW-1:0] idx0,
	output logic        [IW-1:0] idx1,
	output logic        [15:0]   weight,
	output logic                 oor
);

	logic signed [32:0] diff_s1;
	logic        [63:0] prod_s2;
	logic               neg_s2;
	logic        [31:0] whole;
	logic        [31:0] last_ext;
	logic        [IW-1:0] lo_idx;
	logic               out_c;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= $signed({coord[31], coord}) - $signed({origin[31], origin});
			prod_s2 <= 64'(diff_s1[31:0]) * 64'(inv);
			neg_s2  <= diff_s1[32];
		end
	end

	// exact compare against the last grid point
	always_comb begin
		whole    = prod_s2[63:32];
		last_ext = 32'(last);
		lo_idx   = whole[IW-1:0];
		out_c    = neg_s2 || (whole > last_ext) ||
			((whole == last_ext) && (prod_s2[31:0] != 32'd0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx0   <= lo_idx;
			idx1   <= (lo_idx != last) ? lo_idx + IW'(1) : lo_idx;
			weight <= prod_s2[31:16];
			oor    <= out_c;
		end
	end

endmodule

@@ design/gbi_sample_bank.sv @@
// one bank of the sample store: one write port, one registered read port
module gbi_sample_bank #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/gbi_blend.sv @@
// bilinear blend of four corner samples with round to nearest
module gbi_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  gbi_pkg::gbi_ctl_t   ctl,
	input  logic [3:0][31:0]    corner,
	output logic                valid,
	output logic [31:0]         interp_value,
	output logic                out_of_range
);

	localparam logic [41:0] ROUND_HALF = 42'h0_8000_0000;

	logic               v_s5, v_s6, v_s7, v_s8, v_s9;
	logic               oor_s5, oor_s6, oor_s7, oor_s8;
	logic [16:0]        wy0_s5, wy0_s6, wy1_s5, wy1_s6;
	logic signed [49:0] p00_s5, p10_s5, p01_s5, p11_s5;
	logic signed [49:0] row0_s6, row1_s6;
	logic signed [43:0] ph0_s7, ph1_s7;
	logic        [40:0] pl0_s7, pl1_s7;
	logic signed [44:0] hi_s8;
	logic        [41:0] lo_s8;
	logic [31:0]        interp_s9;
	logic               oor_s9;

	logic [16:0]        wx0, wx1;
	logic signed [31:0] f00, f10, f01, f11;
	logic signed [67:0] total;

	// corner pick by bank parity, x weights
	always_comb begin
		wx1 = {1'b0, ctl.dx};
		wx0 = gbi_pkg::WEIGHT_ONE - wx1;
		f00 = $signed(corner[{ctl.x0p, ctl.y0p}]);
		f10 = $signed(corner[{ctl.x1p, ctl.y0p}]);
		f01 = $signed(corner[{ctl.x0p, ctl.y1p}]);
		f11 = $signed(corner[{ctl.x1p, ctl.y1p}]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s5 <= ctl.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// x products
			p00_s5 <= 50'($signed({1'b0, wx0})) * 50'(f00);
			p10_s5 <= 50'($signed({1'b0, wx1})) * 50'(f10);
			p01_s5 <= 50'($signed({1'b0, wx0})) * 50'(f01);
			p11_s5 <= 50'($signed({1'b0, wx1})) * 50'(f11);
			wy1_s5 <= {1'b0, ctl.dy};
			wy0_s5 <= gbi_pkg::WEIGHT_ONE - {1'b0, ctl.dy};
			oor_s5 <= ctl.oor;
			// rows
			row0_s6 <= p00_s5 + p10_s5;
			row1_s6 <= p01_s5 + p11_s5;
			wy0_s6  <= wy0_s5;
			wy1_s6  <= wy1_s5;
			oor_s6  <= oor_s5;
			// y products on split rows
			ph0_s7 <= 44'($signed({1'b0, wy0_s6})) * 44'($signed(row0_s6[49:24]));
			ph1_s7 <= 44'($signed({1'b0, wy1_s6})) * 44'($signed(row1_s6[49:24]));
			pl0_s7 <= 41'(wy0_s6) * 41'(row0_s6[23:0]);
			pl1_s7 <= 41'(wy1_s6) * 41'(row1_s6[23:0]);
			oor_s7 <= oor_s6;
			// partial sums, rounding bias folded into the low half
			hi_s8  <= 45'(ph0_s7) + 45'(ph1_s7);
			lo_s8  <= 42'(pl0_s7) + 42'(pl1_s7) + ROUND_HALF;
			oor_s8 <= oor_s7;
			// final sum
			interp_s9 <= oor_s8 ? 32'd0 : total[63:32];
			oor_s9    <= oor_s8;
		end
	end

	always_comb begin
		total = (68'(hi_s8) <<< 24) + $signed({26'd0, lo_s8});
	end

	assign valid        = v_s9;
	assign interp_value = interp_s9;
	assign out_of_range = oor_s9;

endmodule

@@ test/gbi_checker.sv @@
// checker of the grid bilinear interpolator: predicts every query and compares its result
module gbi_checker
	import gbi_pkg::*;
#(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tready,
	input  logic [111:0]  s_axis_tdata,   // x_bin, y_bin, sample_value, x_coord, y_coord, zero pad
	input  logic [0:0]    s_axis_tuser,   // mode
	input  logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  logic [31:0]   m_axis_tdata,   // interp_value
	input  logic [0:0]    m_axis_tuser,   // out_of_range
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output int            fail_count,
	output int            pending,
	output int            results_seen,
	output int            oor_seen
);

	typedef struct packed {
		logic [31:0] interp_value;
		logic        out_of_range;
	} interp_result_t;

	logic [31:0] x_origin, y_origin, x_inv_width, y_inv_width;
	logic [6:0]  x_points, y_points;
	logic [31:0] grid_copy [MAX_X_POINTS * MAX_Y_POINTS];
	interp_result_t pending_interps [$];
	int errors, compared, flagged;

	function automatic int unsigned points_in_use(logic [6:0] raw, int unsigned limit);
		if (raw < 2) return 2;
		if (raw > limit) return limit;
		return raw;
	endfunction

	// exact mapping into grid units, 32 fraction bits
	function automatic bit axis_to_grid(input logic [31:0] coord, input logic [31:0] origin,
			input logic [31:0] inv, input int unsigned pts,
			output int unsigned idx, output logic [15:0] frac);
		longint offset;
		logic [63:0] offset_u, prod, last_line;
		offset = longint'($signed(coord)) - longint'($signed(origin));
		if (offset < 0) return 1'b0;
		offset_u = offset;
		prod = offset_u * {32'h0, inv};
		last_line = 64'(pts - 1) << 32;
		if (prod > last_line) return 1'b0;
		idx = prod[63:32];
		frac = prod[31:16];
		return 1'b1;
	endfunction

	function automatic longint sample_at(int unsigned ix, int unsigned iy);
		return longint'($signed(grid_copy[ix * MAX_Y_POINTS + iy]));
	endfunction

	function automatic interp_result_t blend_at_point(logic [31:0] xc, logic [31:0] yc);
		int unsigned px, py, ix0, iy0, ix1, iy1;
		logic [15:0] dx, dy;
		bit in_x, in_y;
		longint wx0, wx1, wy0, wy1, row0, row1, acc, rounded;
		interp_result_t res;
		px = points_in_use(x_points, MAX_X_POINTS);
		py = points_in_use(y_points, MAX_Y_POINTS);
		in_x = axis_to_grid(xc, x_origin, x_inv_width, px, ix0, dx);
		in_y = axis_to_grid(yc, y_origin, y_inv_width, py, iy0, dy);
		if (!in_x || !in_y) begin
			res.interp_value = 32'h0;
			res.out_of_range = 1'b1;
			return res;
		end
		// upper neighbour held at the last grid point
		ix1 = (ix0 != px - 1) ? ix0 + 1 : ix0;
		iy1 = (iy0 != py - 1) ? iy0 + 1 : iy0;
		wx1 = longint'(dx);
		wx0 = longint'(WEIGHT_ONE) - wx1;
		wy1 = longint'(dy);
		wy0 = longint'(WEIGHT_ONE) - wy1;
		row0 = wx0 * sample_at(ix0, iy0) + wx1 * sample_at(ix1, iy0);
		row1 = wx0 * sample_at(ix0, iy1) + wx1 * sample_at(ix1, iy1);
		acc = wy0 * row0 + wy1 * row1;
		// nearest, ties upward
		rounded = (acc + 64'sd2147483648) >>> 32;
		res.interp_value = rounded[31:0];
		res.out_of_range = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		interp_result_t want;
		if (!arst_n) begin
			x_origin = 32'h0;
			y_origin = 32'h0;
			x_inv_width = 32'h0001_0000;
			y_inv_width = 32'h0001_0000;
			x_points = 7'd64;
			y_points = 7'd64;
			for (int i = 0; i < MAX_X_POINTS * MAX_Y_POINTS; i++) grid_copy[i] = 32'h0;
			pending_interps.delete();
			errors = 0;
			compared = 0;
			flagged = 0;
		end else begin
			// results first, so a result never meets the query accepted in the same cycle
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_interps.size() == 0) begin
					$error("unexpected result: interp_value %h out_of_range %b",
						m_axis_tdata, m_axis_tuser[0]);
					errors++;
				end else begin
					want = pending_interps.pop_front();
					compared++;
					if (want.out_of_range) flagged++;
					if (m_axis_tdata !== want.interp_value) begin
						$error("interp_value mismatch: expected %h, actual %h",
							want.interp_value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser[0] !== want.out_of_range) begin
						$error("out_of_range mismatch: expected %b, actual %b",
							want.out_of_range, m_axis_tuser[0]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == MODE_QUERY) begin
					pending_interps.push_back(blend_at_point(s_axis_tdata[75:44],
						s_axis_tdata[107:76]));
				end else begin
					grid_copy[s_axis_tdata[5:0] * MAX_Y_POINTS + s_axis_tdata[11:6]] =
						s_axis_tdata[43:12];
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_X_ORIGIN:    x_origin = cfg_data;
					REG_Y_ORIGIN:    y_origin = cfg_data;
					REG_X_INV_WIDTH: x_inv_width = cfg_data;
					REG_Y_INV_WIDTH: y_inv_width = cfg_data;
					REG_X_POINTS:    x_points = cfg_data[6:0];
					REG_Y_POINTS:    y_points = cfg_data[6:0];
					default: ;
				endcase
			end
		end
		fail_count <= errors;
		pending <= pending_interps.size();
		results_seen <= compared;
		oor_seen <= flagged;
	end

endmodule

@@ test/tb_grid_bilinear_interpolator.sv @@
// testbench top of the grid bilinear interpolator: stimulus, register settings and verdict
module tb_grid_bilinear_interpolator;

	localparam int MAX_X_POINTS = 64;
	localparam int MAX_Y_POINTS = 64;
	// pipe depth of nine plus some margin, for the quiet spell before register writes
	localparam int DRAIN_CYCLES = 12;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [111:0]  s_axis_tdata;   // x_bin, y_bin, sample_value, x_coord, y_coord, zero pad
	logic [0:0]    s_axis_tuser;   // mode
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [31:0]   m_axis_tdata;   // interp_value
	logic [0:0]    m_axis_tuser;   // out_of_range
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;

	int fail_count, pending, results_seen, oor_seen;

	// idle switch shared by both stream sides
	bit idle_on;
	int items_sent, queries_sent, settings_loaded;

	// current register values, mirrored so queries can be aimed at the grid
	logic [31:0] cur_x_origin, cur_y_origin, cur_x_inv, cur_y_inv;
	int cur_x_pts, cur_y_pts;

	// store entries that have been written at least once
	bit written [MAX_X_POINTS][MAX_Y_POINTS];

	grid_bilinear_interpolator #(
		.MAX_X_POINTS(MAX_X_POINTS),
		.MAX_Y_POINTS(MAX_Y_POINTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// watches both channels and the register port, predicts and compares
	gbi_checker #(
		.MAX_X_POINTS(MAX_X_POINTS),
		.MAX_Y_POINTS(MAX_Y_POINTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.oor_seen(oor_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// master side: ready drops at random, about 15 percent of the time, while idling is on
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 15);
		end
	end

	// one transaction on the slave side, with a random idle spell before it while idling is on
	task automatic put_item(input logic mode, input logic [5:0] xb, input logic [5:0] yb,
			input logic [31:0] sample, input logic [31:0] xc, input logic [31:0] yc);
		int gaps;
		gaps = 0;
		if (idle_on) begin
			while ($urandom_range(0, 99) < 15) gaps++;
		end
		if (gaps > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {4'h0, yc, xc, sample, yb, xb};
		// ready is read before this edge's updates land, so it is the value that counted
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (mode == gbi_pkg::MODE_QUERY) queries_sent++;
		else written[xb][yb] = 1'b1;
	endtask

	// wait for every result, then let write transactions leave the pipe
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all six registers, only ever called with the block idle
	task automatic load_settings(input logic [31:0] xo, input logic [31:0] yo,
			input logic [31:0] xi, input logic [31:0] yi,
			input logic [6:0] xp, input logic [6:0] yp);
		logic [31:0] vals [6];
		vals[gbi_pkg::REG_X_ORIGIN] = xo;
		vals[gbi_pkg::REG_Y_ORIGIN] = yo;
		vals[gbi_pkg::REG_X_INV_WIDTH] = xi;
		vals[gbi_pkg::REG_Y_INV_WIDTH] = yi;
		vals[gbi_pkg::REG_X_POINTS] = {25'h0, xp};
		vals[gbi_pkg::REG_Y_POINTS] = {25'h0, yp};
		for (int r = 0; r < 6; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_x_origin = xo;
		cur_y_origin = yo;
		cur_x_inv = xi;
		cur_y_inv = yi;
		// counts below two or above the store act as the nearest limit
		cur_x_pts = (xp < 2) ? 2 : (xp > MAX_X_POINTS) ? MAX_X_POINTS : xp;
		cur_y_pts = (yp < 2) ? 2 : (yp > MAX_Y_POINTS) ? MAX_Y_POINTS : yp;
		settings_loaded++;
	endtask

	// sample values with the signed extremes mixed in
	function automatic logic [31:0] pick_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) return 32'h7FFF_FFFF;
		if (pick < 20) return 32'h8000_0000;
		return $urandom;
	endfunction

	// lower grid index near either end of the grid, so few entries are ever touched
	function automatic longint pick_index(int pts);
		int lo_top;
		lo_top = (pts > 4) ? 3 : pts - 1;
		if ($urandom_range(0, 1) == 0) return longint'($urandom_range(0, lo_top));
		return longint'(pts - 1 - $urandom_range(0, 1));
	endfunction

	// a coordinate along one axis, aimed mostly at the grid, its grid lines and its edges
	function automatic logic [31:0] pick_coord(logic [31:0] origin, logic [31:0] inv, int pts);
		longint span, pos, offset;
		int unsigned pick;
		span = longint'(pts - 1) << 32;
		pick = $urandom_range(0, 99);
		if (pick < 15) return $urandom;
		if (pick < 30) pos = span;
		else if (pick < 40) pos = pick_index(pts) << 32;
		else if (pick < 45) pos = -longint'($urandom_range(1, 1 << 20));
		else pos = (pick_index(pts) << 32) + longint'($urandom);
		if (inv == 32'h0) begin
			// zero reciprocal width: only the side of the origin matters
			offset = (pos < 0) ? -longint'($urandom_range(1, 255))
				: longint'($urandom_range(0, 1 << 24));
		end else begin
			// one step either side lands on both sides of exact boundaries
			offset = pos / longint'(inv) + longint'($urandom_range(0, 2)) - 1;
		end
		return 32'(longint'($signed(origin)) + offset);
	endfunction

	// lower grid index of a coordinate under the current settings, 0 when off the grid
	function automatic bit lower_index(input logic [31:0] coord, input logic [31:0] origin,
			input logic [31:0] inv, input int pts, output int idx);
		longint offset;
		logic [63:0] prod;
		idx = 0;
		offset = longint'($signed(coord)) - longint'($signed(origin));
		if (offset < 0) return 1'b0;
		prod = 64'(offset) * 64'(inv);
		if (prod > (64'(pts - 1) << 32)) return 1'b0;
		idx = int'(prod[63:32]);
		return 1'b1;
	endfunction

	// writes an entry unless it already holds a sample
	task automatic fill_entry(input int ix, input int iy);
		if (!written[ix][iy]) begin
			put_item(gbi_pkg::MODE_WRITE, 6'(ix), 6'(iy), pick_sample(), $urandom, $urandom);
		end
	endtask

	// a query, with every corner it reads written beforehand
	task automatic put_query(input logic [31:0] xc, input logic [31:0] yc);
		int ix0, iy0, ix1, iy1;
		bit in_x, in_y;
		in_x = lower_index(xc, cur_x_origin, cur_x_inv, cur_x_pts, ix0);
		in_y = lower_index(yc, cur_y_origin, cur_y_inv, cur_y_pts, iy0);
		if (in_x && in_y) begin
			ix1 = (ix0 != cur_x_pts - 1) ? ix0 + 1 : ix0;
			iy1 = (iy0 != cur_y_pts - 1) ? iy0 + 1 : iy0;
			fill_entry(ix0, iy0);
			fill_entry(ix1, iy0);
			fill_entry(ix0, iy1);
			fill_entry(ix1, iy1);
		end
		put_item(gbi_pkg::MODE_QUERY, 6'($urandom), 6'($urandom), $urandom, xc, yc);
	endtask

	// mostly queries at the grid, the rest sample writes anywhere in the store
	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 30) begin
				put_item(gbi_pkg::MODE_WRITE, 6'($urandom), 6'($urandom), pick_sample(),
					$urandom, $urandom);
			end else begin
				put_query(pick_coord(cur_x_origin, cur_x_inv, cur_x_pts),
					pick_coord(cur_y_origin, cur_y_inv, cur_y_pts));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= gbi_pkg::MODE_WRITE;
		cfg_we <= 1'b0;
		cfg_index <= gbi_pkg::REG_X_ORIGIN;
		cfg_data <= 32'h0;
		idle_on = 1'b1;
		items_sent = 0;
		queries_sent = 0;
		settings_loaded = 0;
		// reset values of the registers
		cur_x_origin = 32'h0;
		cur_y_origin = 32'h0;
		cur_x_inv = 32'h0001_0000;
		cur_y_inv = 32'h0001_0000;
		cur_x_pts = 64;
		cur_y_pts = 64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the store is not cleared by reset, so a query's corners are written before it

		// directed: signed extremes in the corners under the reset settings
		put_item(gbi_pkg::MODE_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd1, 6'd0, 32'h8000_0000, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd0, 6'd1, 32'h8000_0000, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd1, 6'd1, 32'h7FFF_FFFF, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd63, 6'd63, 32'h7FFF_FFFF, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd62, 6'd63, 32'h8000_0000, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd63, 6'd62, 32'h0, 32'h0, 32'h0);
		put_item(gbi_pkg::MODE_WRITE, 6'd62, 6'd62, 32'hFFFF_0000, 32'h0, 32'h0);
		// exactly on a grid point
		put_query(32'h0000_0000, 32'h0000_0000);
		// centre of the extreme cell: a rounding tie
		put_query(32'h0000_8000, 32'h0000_8000);
		// largest weights
		put_query(32'h0000_FFFF, 32'h0000_FFFF);
		put_query(32'h0001_0000, 32'h0000_0000);
		// last grid point on one or both axes: upper neighbours held
		put_query(32'h003F_0000, 32'h003F_0000);
		put_query(32'h003E_8000, 32'h003F_0000);
		put_query(32'h003F_0000, 32'h003E_C000);
		// one step past the last grid line on each axis
		put_query(32'h003F_0001, 32'h0000_0000);
		put_query(32'h0000_0000, 32'h003F_0001);
		// below the origin and at the coordinate extremes
		put_query(32'hFFFF_FFFF, 32'h0000_0000);
		put_query(32'h0000_0000, 32'h8000_0000);
		put_query(32'h7FFF_FFFF, 32'h0000_0000);

		random_phase(70);

		// small grid, shifted origins, bins of width two and one half
		settle();
		load_settings(32'hFFFB_0000, 32'h0003_8000, 32'h0000_8000, 32'h0002_0000,
			7'd2, 7'd3);
		random_phase(55);

		// x: lowest origin, zero reciprocal width, count below two
		// y: widest reciprocal, count above the store
		settle();
		load_settings(32'h8000_0000, 32'hFFF0_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			7'd1, 7'd127);
		random_phase(40);

		// the mirror image: highest x origin, zero y reciprocal width, counts of 65 and zero
		settle();
		load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
			7'd65, 7'd0);
		random_phase(30);

		// random settings with both sides streaming flat out
		settle();
		idle_on = 1'b0;
		load_settings($urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
			$urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
			$urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
			7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)));
		random_phase(75);

		// back to the reset settings, idling again
		settle();
		idle_on = 1'b1;
		load_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 7'd64, 7'd64);
		random_phase(50);

		settle();
		$display("covered %0d stream transactions (%0d queries) under %0d register settings",
			items_sent, queries_sent, settings_loaded + 1);
		$display("compared %0d results, %0d of them flagged outside the grid",
			results_seen, oor_seen);
		if (fail_count == 0) begin
			$display("tb_grid_bilinear_interpolator: done, clean");
		end else begin
			$display("tb_grid_bilinear_interpolator: done, errors");
		end
		$finish;
	end

	// a hung handshake or a missing result ends here
	initial begin
		#2_000_000;
		$display("tb_grid_bilinear_interpolator: done, errors");
		$finish;
	end

endmodule
